[rtl/stbs_pkg.sv]
// Shared types, constants and helpers for the sorted table bracket search block.
// Standalone package; imported by stbs_cmp, stbs_seq and the top level.
package stbs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 7;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = 6;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIRST  = 7'b0000010,
    S_LAST   = 7'b0000100,
    S_ENDS   = 7'b0001000,
    S_ORIENT = 7'b0010000,
    S_STEP   = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_res_t;

  // Clamp a programmed length into the usable range of the table.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v < LEN_MIN) r = LEN_MIN;
    if (v > LEN_W'(TABLE_DEPTH)) r = LEN_W'(TABLE_DEPTH);
    return r;
  endfunction

endpackage

[rtl/stbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/stbs_cmp.sv]
// Shared signed compare unit: equality and greater-or-equal of two Q16.16 keys.
// Depends on stbs_pkg.
module stbs_cmp (
  input  logic signed [stbs_pkg::KEY_W-1:0] op_a,
  input  logic signed [stbs_pkg::KEY_W-1:0] op_b,
  output stbs_pkg::cmp_res_t                res
);
  import stbs_pkg::*;

  always_comb begin
    res.eq = (op_a == op_b);
    res.ge = (op_a >= op_b);
  end

endmodule

[rtl/stbs_seq.sv]
// Search sequencer: accepts transactions, writes the key table, runs the end
// checks and the bisection through the shared compare unit, holds the result.
// Depends on stbs_pkg and stbs_cmp.
module stbs_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [stbs_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_key_value,
  input  logic [stbs_pkg::LEN_W-1:0]        table_length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stbs_pkg::IDX_W-1:0]        out_lower_index,
  output stbs_pkg::ram_req_t                ram_req,
  input  logic [stbs_pkg::KEY_W-1:0]        ram_rdata
);
  import stbs_pkg::*;

  state_t state_r, state_nxt;

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] first_r, first_nxt;
  logic signed [KEY_W-1:0] last_r, last_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] lo_r, lo_nxt;
  logic [LEN_W-1:0] hi_r, hi_nxt;
  logic [LEN_W-1:0] mid_r, mid_nxt;
  logic             asc_r, asc_nxt;
  logic [IDX_W-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic signed [KEY_W-1:0] op_a, op_b;
  cmp_res_t         cmp;
  logic             accept;
  logic             go_up;
  logic [LEN_W-1:0] step_lo, step_hi, step_mid, step_gap;
  logic [LEN_W:0]   step_sum;
  logic [LEN_W-1:0] len_m1, len_m2;

  stbs_cmp u_cmp (
    .op_a (op_a),
    .op_b (op_b),
    .res  (cmp)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign accept          = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_lower_index = out_idx_r;

  assign len_m1 = len_r - LEN_W'(1);
  assign len_m2 = len_r - LEN_W'(2);

  // Orientation compares the two end entries; every other step compares the key.
  always_comb begin
    if (state_r == S_ORIENT) begin
      op_a = last_r;
      op_b = first_r;
    end else begin
      op_a = key_r;
      op_b = ram_rdata;
    end
  end

  always_comb begin
    go_up    = (cmp.ge == asc_r);
    step_lo  = go_up ? mid_r : lo_r;
    step_hi  = go_up ? hi_r : mid_r;
    step_sum = {1'b0, step_lo} + {1'b0, step_hi};
    step_mid = step_sum[LEN_W:1];
    step_gap = step_hi - step_lo;
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    len_nxt       = len_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    asc_nxt       = asc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;

    ram_req.we    = accept && (in_mode == MODE_WRITE);
    ram_req.waddr = in_entry_index[ADDR_W-1:0];
    ram_req.wdata = in_key_value;
    ram_req.raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_SEARCH)) begin
          key_nxt   = in_key_value;
          len_nxt   = sat_len(table_length);
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        ram_req.raddr = '0;
        state_nxt     = S_LAST;
      end
      S_LAST: begin
        ram_req.raddr = len_m1[ADDR_W-1:0];
        first_nxt     = ram_rdata;
        if (cmp.eq) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ENDS;
        end
      end
      S_ENDS: begin
        last_nxt = ram_rdata;
        if (cmp.eq) begin
          res_nxt   = len_m2[IDX_W-1:0];
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ORIENT;
        end
      end
      S_ORIENT: begin
        asc_nxt       = cmp.ge;
        lo_nxt        = '0;
        hi_nxt        = len_r;
        mid_nxt       = len_r >> 1;
        ram_req.raddr = mid_nxt[ADDR_W-1:0];
        state_nxt     = S_STEP;
      end
      S_STEP: begin
        lo_nxt  = step_lo;
        hi_nxt  = step_hi;
        mid_nxt = step_mid;
        if (step_gap > LEN_W'(1)) begin
          ram_req.raddr = step_mid[ADDR_W-1:0];
        end else begin
          res_nxt   = step_lo[IDX_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    len_r     <= len_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    asc_r     <= asc_nxt;
    res_r     <= res_nxt;
    out_idx_r <= out_idx_nxt;
  end

endmodule

[rtl/sorted_table_bracket_search_top.sv]
// Top level of the sorted table bracket search block: key table RAM, sequencer
// and the table length register. Depends on stbs_pkg, stbs_ram and stbs_seq.
//
// Usage
//   Input channel (in_valid / in_stall): each transaction carries in_mode,
//   in_entry_index and in_key_value. Mode write stores the signed Q16.16 key at
//   in_entry_index and produces no result. Mode search looks up in_key_value
//   in entries 0 .. length-1 and returns the lower bracket index on the
//   output channel (out_valid / out_stall, out_lower_index).
//   The table may be ascending or descending; the direction comes from the
//   two end entries. Keys beyond either end clamp to 0 or length-1.
//   cfg_wr_en / cfg_wr_data set the table length (clamped to 2 .. depth);
//   write it only while the block is idle.
// Stalls
//   A write does not hold in_stall; the next transaction can follow at once.
//   A search holds in_stall through the end checks, the orientation set-up,
//   the bisection steps (at most ceil(log2(length)), exactly six for 64
//   entries) and the hand-over to the output register, which waits while a
//   pending result is stalled.
//   A key matching the first entry ends the search after the first end check,
//   one matching the last entry after the second; neither runs the bisection.
// Reset and back-pressure
//   rst_n (synchronous, active low) clears the sequencer and output valid and
//   sets the length to 64; table contents are undefined until written.
//   A finished result sits in the output register while out_stall is high; the
//   block still accepts a new transaction, and a second result waits until the
//   register is free.
module sorted_table_bracket_search_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [stbs_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_key_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stbs_pkg::IDX_W-1:0]        out_lower_index,
  input  logic                              cfg_wr_en,
  input  logic [stbs_pkg::LEN_W-1:0]        cfg_wr_data
);
  import stbs_pkg::*;

  logic [LEN_W-1:0] table_length_r, table_length_nxt;
  ram_req_t         ram_req;
  logic [KEY_W-1:0] ram_rdata;

  // Table length register: taken raw, clamped when a search starts.
  assign table_length_nxt = cfg_wr_en ? cfg_wr_data : table_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= LEN_RESET;
    end else begin
      table_length_r <= table_length_nxt;
    end
  end

  // Key table storage.
  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Sequencer with the shared compare unit and the output register.
  stbs_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_entry_index  (in_entry_index),
    .in_key_value    (in_key_value),
    .table_length    (table_length_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lower_index (out_lower_index),
    .ram_req         (ram_req),
    .ram_rdata       (ram_rdata)
  );

  // A search transaction occupies the sequencer on the following cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_SEARCH) |=> in_stall)
    else $error("search accepted but input not held off");

  // A table write never occupies the sequencer.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_WRITE) |=> !in_stall)
    else $error("table write left the block busy");

  // The table is written only while no search is in flight.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !in_stall)
    else $error("table write during a search");

  // A new result appears only when the output register was free or drained.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lower_index))
    else $error("pending result dropped or overwritten");

endmodule
